>>> rtl/core/ise_pkg.sv
// ise_pkg: shared types and constants for the integer sort engine.
// Used by ise_ram, integer_sort_engine_core and ise_chk; no dependencies.
package ise_pkg;

	localparam int DATA_W = 16;

	// input word: one element of the set, last_item closes the set
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last_item;
	} in_word_t;

	// output word: one element of the sorted run
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last_result;
		logic                     overflow;
	} out_word_t;

endpackage

>>> rtl/core/ise_ram.sv
// ise_ram: element store, one write port and one read port, registered read.
// Depends on ise_pkg for the data width.
module ise_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ise_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [ise_pkg::DATA_W-1:0] rdata
);
	import ise_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/integer_sort_engine_core.sv
// Load: one input word per cycle while in LOAD; the word flagged last_item closes the set.
// Sort (sets of n > 1): in-place insertion sort in the element store; a start
// state KEY_RD, then per key a KEY_WAIT fetch, CMP shifts, and PLACE at entry 0.
// Emit: each result is read (EMIT_RD, held while the output is stalled), then loaded (EMIT_LD).
// Reset (arst_n low) clears count, overflow and control state; store not cleared.
module integer_sort_engine_core #(
	parameter int MAX_ELEMENTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ise_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ise_pkg::out_word_t out_data
);
	import ise_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

	// LOAD takes words; KEY_RD/KEY_WAIT fetch the next key and its left
	// neighbour; CMP shifts larger elements up one per cycle; PLACE writes a
	// key that has travelled down to entry 0; EMIT_RD/EMIT_LD stream results.
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_KEY_RD,
		ST_KEY_WAIT,
		ST_CMP,
		ST_PLACE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            cnt_q;     // elements held in the open set
	logic                     drop_q;    // a word was dropped from the open set
	logic [CW-1:0]            n_q;       // size of the closed set
	logic                     ovf_q;     // closed set lost words
	logic [AW-1:0]            i_q;       // index of the key being inserted
	logic [AW-1:0]            j_q;       // current hole position
	logic [AW-1:0]            k_q;       // emit index
	logic signed [DATA_W-1:0] key_q;
	logic                     out_valid_q;
	out_word_t                out_data_q;

	// store ports
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	logic          in_accept;
	logic          cnt_full;
	logic [CW-1:0] n_close;
	logic          key_is_end;
	logic          emit_is_end;
	logic          greater;
	logic          out_free;

	assign in_ready    = (state_q == ST_LOAD);
	assign in_accept   = in_valid && in_ready;
	assign cnt_full    = (cnt_q == MAX_CNT);
	assign n_close     = cnt_full ? cnt_q : cnt_q + CW'(1);
	assign key_is_end  = ((CW'(i_q) + CW'(1)) == n_q);
	assign emit_is_end = ((CW'(k_q) + CW'(1)) == n_q);
	assign greater     = ($signed(mem_rdata) > key_q);
	assign out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Store access. Reads and writes in the same cycle always hit different
	// entries (shift writes at j while reading j-2; key writes at j <= i while
	// reading i+1), and every read of a just-written entry comes in a later cycle,
	// so no forwarding is needed.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_accept && !cnt_full) begin
					mem_we    = 1'b1;
					mem_waddr = cnt_q[AW-1:0];
					mem_wdata = in_data.value;
				end
			end
			ST_KEY_RD: begin
				mem_re    = 1'b1;
				mem_raddr = i_q;
			end
			ST_KEY_WAIT: begin
				mem_re    = 1'b1;
				mem_raddr = i_q - AW'(1);
			end
			ST_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				if (greater) begin
					// shift the larger element up, fetch the next neighbour
					mem_wdata = mem_rdata;
					if (j_q != AW'(1)) begin
						mem_re    = 1'b1;
						mem_raddr = j_q - AW'(2);
					end
				end else begin
					mem_wdata = key_q;
					if (!key_is_end) begin
						mem_re    = 1'b1;
						mem_raddr = i_q + AW'(1);
					end
				end
			end
			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = key_q;
				if (!key_is_end) begin
					mem_re    = 1'b1;
					mem_raddr = i_q + AW'(1);
				end
			end
			ST_EMIT_RD: begin
				if (out_free) begin
					mem_re    = 1'b1;
					mem_raddr = k_q;
				end
			end
			ST_EMIT_LD: begin
			end
			default: begin
			end
		endcase
	end

	ise_ram #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			n_q         <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_accept) begin
						if (!cnt_full) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (in_data.last_item) begin
							// close the set and open an empty one
							n_q    <= n_close;
							ovf_q  <= drop_q || cnt_full;
							cnt_q  <= '0;
							drop_q <= 1'b0;
							k_q    <= '0;
							i_q    <= AW'(1);
							if (n_close == CW'(1)) begin
								state_q <= ST_EMIT_RD;
							end else begin
								state_q <= ST_KEY_RD;
							end
						end
					end
				end
				ST_KEY_RD: begin
					state_q <= ST_KEY_WAIT;
				end
				ST_KEY_WAIT: begin
					key_q   <= $signed(mem_rdata);
					j_q     <= i_q;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (greater) begin
						j_q <= j_q - AW'(1);
						if (j_q == AW'(1)) begin
							state_q <= ST_PLACE;
						end
					end else if (key_is_end) begin
						state_q <= ST_EMIT_RD;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= ST_KEY_WAIT;
					end
				end
				ST_PLACE: begin
					if (key_is_end) begin
						state_q <= ST_EMIT_RD;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= ST_KEY_WAIT;
					end
				end
				ST_EMIT_RD: begin
					if (out_free) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD: begin
					// output register is empty here: the read was only issued
					// once it was free
					out_valid_q             <= 1'b1;
					out_data_q.sorted_value <= $signed(mem_rdata);
					out_data_q.last_result  <= emit_is_end;
					out_data_q.overflow     <= ovf_q;
					if (emit_is_end) begin
						state_q <= ST_LOAD;
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/ise_chk.sv
// ise_props: port-level checks for integer_sort_engine_core, bound to the top.
// Depends on ise_pkg for the word types.
module ise_props (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input ise_pkg::in_word_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input ise_pkg::out_word_t out_data
);
	import ise_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// no new words while a sorted run is still streaming
	a_no_load_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_result |-> !in_ready)
		else $error("input open during a sorted run");

	// closing a set stops intake for the sort
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_item |=> !in_ready)
		else $error("input still open after closing word");

	// a result word only appears from an emit cycle
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word raised while loading");

endmodule

bind integer_sort_engine_core ise_props u_ise_props (.*);
